### src/swe_obg_pkg.sv
`timescale 1ns / 1ps
package swe_obg_pkg;

    localparam int GRAV_W = 25;
    localparam int RAD_W  = 56;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 25'd642908;

    typedef enum logic [2:0] {
        KIND_ZERO_GRAD     = 3'd0,
        KIND_CLAMP_ALL     = 3'd1,
        KIND_CLAMP_DEPTH   = 3'd2,
        KIND_CLAMP_FLOW    = 3'd3,
        KIND_FLATHER_DEPTH = 3'd4,
        KIND_FLATHER_FLOW  = 3'd5
    } kind_t;

    typedef struct packed {
        logic               flather;
        logic               status;
        logic signed [31:0] gh;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gex;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [50:0] qn_ext;
        logic signed [50:0] qv_raw;
        logic signed [32:0] dh;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### src/swe_obg_front.sv
`timescale 1ns / 1ps
module swe_obg_front
    import swe_obg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2:0]        kind,
    input  logic [263:0]      data,
    input  logic [GRAV_W-1:0] gravity,
    output logic              valid,
    output logic [RAD_W-1:0]  rad,
    output side_t             side
);

    logic signed [17:0] nx, ny;
    logic signed [31:0] h, qx, qy, ex, he, qxe, qye;
    logic [30:0]        hpos;
    side_t              side_next;
    logic [RAD_W-1:0]   rad_next;
    side_t              side_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic               valid_reg;
    logic signed [31:0] mir_h, mir_x, mir_y;

    assign nx  = data[17:0];
    assign ny  = data[35:18];
    assign h   = data[67:36];
    assign qx  = data[99:68];
    assign qy  = data[131:100];
    assign ex  = data[163:132];
    assign he  = data[195:164];
    assign qxe = data[227:196];
    assign qye = data[259:228];

    assign hpos  = h[31] ? 31'd0 : h[30:0];
    assign mir_h = sat32(66'(he) + 66'(he) - 66'(h));
    assign mir_x = sat32(66'(qxe) + 66'(qxe) - 66'(qx));
    assign mir_y = sat32(66'(qye) + 66'(qye) - 66'(qy));

    always_comb
    begin
        rad_next            = RAD_W'(gravity) * RAD_W'(hpos);
        side_next.flather   = 1'b0;
        side_next.status    = 1'b0;
        side_next.gh        = h;
        side_next.gx        = qx;
        side_next.gy        = qy;
        side_next.gex       = ex;
        side_next.nx        = nx;
        side_next.ny        = ny;
        side_next.qn_ext    = 51'(qxe) * 51'(nx) + 51'(qye) * 51'(ny);
        side_next.qv_raw    = 51'(qye) * 51'(nx) - 51'(qxe) * 51'(ny);
        side_next.dh        = 33'(he) - 33'(h);
        case (kind)
            KIND_ZERO_GRAD, KIND_FLATHER_DEPTH:
            begin
            end
            KIND_CLAMP_ALL:
            begin
                side_next.gh = mir_h;
                side_next.gx = mir_x;
                side_next.gy = mir_y;
            end
            KIND_CLAMP_DEPTH:
            begin
                side_next.gh = mir_h;
            end
            KIND_CLAMP_FLOW:
            begin
                side_next.gx = mir_x;
                side_next.gy = mir_y;
            end
            KIND_FLATHER_FLOW:
            begin
                side_next.flather = 1'b1;
            end
            default:
            begin
                side_next.status = 1'b1;
                side_next.gh     = '0;
                side_next.gx     = '0;
                side_next.gy     = '0;
                side_next.gex    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            rad_reg  <= rad_next;
        end
    end

    assign valid = valid_reg;
    assign rad   = rad_reg;
    assign side  = side_reg;

endmodule

### src/swe_obg_sqrt.sv
`timescale 1ns / 1ps
module swe_obg_sqrt
    import swe_obg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  side_t             in_side,
    output logic              valid,
    output logic [ROOT_W-1:0] root,
    output side_t             side
);

    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        side_t             side_in;
        logic              valid_in;
        logic [REM_W:0]    shifted;
        logic [REM_W:0]    trial;
        logic [REM_W:0]    diff;

        if (i == 0)
        begin : g_first
            assign rad_in   = rad;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign rad_in   = rad_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign shifted = {rem_in[REM_W-2:0], rad_in[RAD_W-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};
        assign diff    = shifted - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[i] <= side_in;
                if (shifted >= trial)
                begin
                    rem_reg[i]  <= diff[REM_W-1:0];
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= shifted[REM_W-1:0];
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign valid = valid_reg[ROOT_W-1];
    assign root  = root_reg[ROOT_W-1];
    assign side  = side_reg[ROOT_W-1];

endmodule

### src/swe_obg_back.sv
`timescale 1ns / 1ps
module swe_obg_back
    import swe_obg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] root,
    input  side_t             in_side,
    output logic              valid,
    output logic [127:0]      data,
    output logic              status
);

    localparam logic signed [45:0] QMAX = 46'sh1fffffffffff;
    localparam logic signed [45:0] QMIN = 46'sh200000000000;

    function automatic logic signed [45:0] rnd_sat46(input logic signed [61:0] v);
        logic signed [61:0] s;
        logic signed [45:0] r;
        s = (v + 62'sd32768) >>> 16;
        if (s > 62'(QMAX))
        begin
            r = QMAX;
        end
        else if (s < 62'(QMIN))
        begin
            r = QMIN;
        end
        else
        begin
            r = s[45:0];
        end
        return r;
    endfunction

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    side_t              s1_reg, s2_reg, s3_reg;
    logic signed [61:0] prod_reg;
    logic signed [45:0] qn_reg, qv_reg;
    logic signed [41:0] nlo_x_reg, nhi_x_reg, nlo_y_reg, nhi_y_reg;
    logic signed [41:0] vlo_x_reg, vhi_x_reg, vlo_y_reg, vhi_y_reg;
    logic [127:0]       data_reg;
    logic               status_reg;
    logic signed [23:0] qn_lo, qv_lo;
    logic signed [22:0] qn_hi, qv_hi;
    logic signed [65:0] fx_raw, fy_raw;
    logic signed [31:0] fx, fy, ox, oy;

    assign qn_lo = $signed({1'b0, qn_reg[22:0]});
    assign qn_hi = qn_reg[45:23];
    assign qv_lo = $signed({1'b0, qv_reg[22:0]});
    assign qv_hi = qv_reg[45:23];

    assign fx_raw = (66'(nhi_x_reg) <<< 23) + 66'(nlo_x_reg)
                  - (66'(vhi_y_reg) <<< 23) - 66'(vlo_y_reg);
    assign fy_raw = (66'(nhi_y_reg) <<< 23) + 66'(nlo_y_reg)
                  + (66'(vhi_x_reg) <<< 23) + 66'(vlo_x_reg);
    assign fx     = sat32((fx_raw + 66'sd32768) >>> 16);
    assign fy     = sat32((fy_raw + 66'sd32768) >>> 16);
    assign ox     = s3_reg.flather ? fx : s3_reg.gx;
    assign oy     = s3_reg.flather ? fy : s3_reg.gy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= in_side;
            prod_reg  <= 62'($signed({1'b0, root})) * 62'(in_side.dh);
            s2_reg    <= s1_reg;
            qn_reg    <= rnd_sat46(62'(s1_reg.qn_ext) - prod_reg);
            qv_reg    <= rnd_sat46(62'(s1_reg.qv_raw));
            s3_reg    <= s2_reg;
            nlo_x_reg <= 42'(qn_lo) * 42'(s2_reg.nx);
            nhi_x_reg <= 42'(qn_hi) * 42'(s2_reg.nx);
            nlo_y_reg <= 42'(qn_lo) * 42'(s2_reg.ny);
            nhi_y_reg <= 42'(qn_hi) * 42'(s2_reg.ny);
            vlo_x_reg <= 42'(qv_lo) * 42'(s2_reg.nx);
            vhi_x_reg <= 42'(qv_hi) * 42'(s2_reg.nx);
            vlo_y_reg <= 42'(qv_lo) * 42'(s2_reg.ny);
            vhi_y_reg <= 42'(qv_hi) * 42'(s2_reg.ny);
            data_reg   <= {s3_reg.gex, oy, ox, s3_reg.gh};
            status_reg <= s3_reg.status;
        end
    end

    assign valid  = v4_reg;
    assign data   = data_reg;
    assign status = status_reg;

endmodule

### src/swe_open_boundary_ghost_unit.sv
`timescale 1ns / 1ps
// An accepted input beat passes to its output beat through one input
// stage, 28 square-root stages (one root bit per stage), and four Flather stages.
// Throughput is one beat per cycle; the whole pipeline holds while an output waits.
// rst_n clears all valid bits asynchronously and loads gravity with 9.81.
module swe_open_boundary_ghost_unit
    import swe_obg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GRAV_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // normal_x, normal_y, interior_depth, interior_flux_x, interior_flux_y,
    // interior_extra, external_depth, external_flux_x, external_flux_y, zero pad
    input  logic [263:0]      s_axis_tdata,
    // kind
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // ghost_depth, ghost_flux_x, ghost_flux_y, ghost_extra
    output logic [127:0]      m_axis_tdata,
    // status
    output logic              m_axis_tuser
);

    logic [GRAV_W-1:0] gravity_reg;
    logic              en;
    logic              f_valid, q_valid;
    logic [RAD_W-1:0]  f_rad;
    side_t             f_side, q_side;
    logic [ROOT_W-1:0] q_root;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            gravity_reg <= cfg_data;
        end
    end

    swe_obg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .kind     (s_axis_tuser),
        .data     (s_axis_tdata),
        .gravity  (gravity_reg),
        .valid    (f_valid),
        .rad      (f_rad),
        .side     (f_side)
    );

    swe_obg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .rad      (f_rad),
        .in_side  (f_side),
        .valid    (q_valid),
        .root     (q_root),
        .side     (q_side)
    );

    swe_obg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (q_valid),
        .root     (q_root),
        .in_side  (q_side),
        .valid    (m_axis_tvalid),
        .data     (m_axis_tdata),
        .status   (m_axis_tuser)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output is empty");

    a_bad_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("unknown kind produced nonzero data");

endmodule
